>>> rtl/i2a_pkg.sv
// i2a_pkg: shared types, constants and helpers of the integer to ascii formatter
// used by i2a_ctrl, i2a_dp and integer_to_ascii_formatter; no dependencies
package i2a_pkg;

	localparam int DIGIT_DEPTH = 20;
	localparam int IDX_W = $clog2(DIGIT_DEPTH);
	localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	localparam logic [3:0] DEC_RADIX   = 4'd10;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

	localparam logic [1:0] SEL_PAD   = 2'd0;
	localparam logic [1:0] SEL_SIGN  = 2'd1;
	localparam logic [1:0] SEL_DIGIT = 2'd2;

	typedef struct packed {
		logic [63:0] value;
		logic        base_ten;
		logic        zero_fill;
		logic        signed_mode;
		logic [7:0]  pad_width;
	} in_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_t;

	typedef struct packed {
		logic       load;
		logic       shift;
		logic       prep;
		logic       emit;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic pad_zero;
		logic neg;
		logic idx_zero;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d >= DEC_RADIX)
			return CH_UPPER_A + 8'(d) - 8'(DEC_RADIX);
		else
			return CH_ZERO + 8'(d);
	endfunction

endpackage

>>> rtl/i2a_ctrl.sv
// i2a_ctrl: sequencer of the formatter, drives commands into i2a_dp
// depends on i2a_pkg
module i2a_ctrl #(
	parameter int VALUE_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2a_pkg::sts_t  sts,
	output i2a_pkg::cmd_t  cmd
);
	import i2a_pkg::*;

	localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_SIGN = 3'd4;
	localparam logic [2:0] ST_DIG  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [BIT_W-1:0] bit_q, bit_d;

	always_comb begin
		state_d = state_q;
		bit_d = bit_q;
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					bit_d = BIT_W'(VALUE_BITS - 1);
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (bit_q == '0)
					state_d = ST_PREP;
				else
					bit_d = bit_q - BIT_W'(1);
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_PAD;
			end
			ST_PAD: begin
				cmd.sel = SEL_PAD;
				if (sts.pad_zero)
					state_d = sts.neg ? ST_SIGN : ST_DIG;
				else if (sts.out_free)
					cmd.emit = 1'b1;
			end
			ST_SIGN: begin
				cmd.sel = SEL_SIGN;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_DIG;
				end
			end
			ST_DIG: begin
				cmd.sel = SEL_DIGIT;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.idx_zero)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			bit_q <= bit_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("character issued while output register busy");

	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && bit_q == '0) |=> state_q == ST_PREP)
		else $error("conversion did not end after last bit");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CONV && bit_q == BIT_W'(VALUE_BITS - 1)))
		else $error("accepted transaction did not start conversion");

endmodule

>>> rtl/i2a_dp.sv
// i2a_dp: datapath of the formatter, bit-serial binary to bcd or hex digit
// shifter, digit count tracking, pad logic and output register; depends on i2a_pkg
module i2a_dp #(
	parameter int MAX_PAD    = 63,
	parameter int VALUE_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  i2a_pkg::in_t  in_data,
	input  i2a_pkg::cmd_t cmd,
	output i2a_pkg::sts_t sts,
	input  logic          out_ready,
	output logic          out_valid,
	output i2a_pkg::out_t out_data
);
	import i2a_pkg::*;

	localparam int PAD_W = $clog2(MAX_PAD + 1);

	logic [VALUE_BITS-1:0] val_q, in_val, in_mag;
	logic in_neg;
	logic [3:0] digit_q [DIGIT_DEPTH];
	logic [3:0] adj [DIGIT_DEPTH];
	logic [3:0] nd [DIGIT_DEPTH];
	logic [DIGIT_DEPTH-1:0] nz, pos_q;
	logic grow;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [PAD_W-1:0] pad_q, pad_left_q, pad_sat;
	logic neg_q, ten_q, zf_q;
	logic [7:0] printed, pad_ext, pad_diff;
	logic [7:0] ch;
	logic out_valid_q;
	out_t out_q;

	assign in_val = in_data.value[VALUE_BITS-1:0];
	assign in_neg = in_data.signed_mode & in_val[VALUE_BITS-1];
	assign in_mag = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;
	assign pad_sat = (in_data.pad_width > 8'(MAX_PAD)) ? PAD_W'(MAX_PAD)
		: in_data.pad_width[PAD_W-1:0];

	// add-3 correction in decimal mode, then shift one bit in
	always_comb begin
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			adj[i] = (ten_q && digit_q[i] >= BCD_ADJ_MIN) ? digit_q[i] + BCD_ADJ_ADD
				: digit_q[i];
		end
		nd[0] = {adj[0][2:0], val_q[VALUE_BITS-1]};
		for (int i = 1; i < DIGIT_DEPTH; i++) begin
			nd[i] = {adj[i][2:0], adj[i-1][3]};
		end
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			nz[i] = (nd[i] != 4'd0);
		end
	end

	assign grow = |(nz & pos_q);

	assign printed = 8'(cnt_q) + 8'(neg_q);
	assign pad_ext = 8'(pad_q);
	assign pad_diff = pad_ext - printed;

	always_comb begin
		case (cmd.sel)
			SEL_PAD:   ch = zf_q ? CH_ZERO : CH_SPACE;
			SEL_SIGN:  ch = CH_MINUS;
			SEL_DIGIT: ch = digit_char(digit_q[idx_q]);
			default:   ch = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < DIGIT_DEPTH; i++)
				digit_q[i] <= 4'd0;
			val_q <= in_mag;
			neg_q <= in_neg;
			ten_q <= in_data.base_ten;
			zf_q <= in_data.zero_fill;
			pad_q <= pad_sat;
		end else if (cmd.shift) begin
			for (int i = 0; i < DIGIT_DEPTH; i++)
				digit_q[i] <= nd[i];
			val_q <= val_q << 1;
		end
		if (cmd.prep) begin
			pad_left_q <= (pad_ext > printed) ? pad_diff[PAD_W-1:0] : '0;
			idx_q <= IDX_W'(cnt_q - CNT_W'(1));
		end else if (cmd.emit) begin
			if (cmd.sel == SEL_PAD)
				pad_left_q <= pad_left_q - PAD_W'(1);
			if (cmd.sel == SEL_DIGIT)
				idx_q <= idx_q - IDX_W'(1);
		end
		if (cmd.emit) begin
			out_q.character <= ch;
			out_q.last <= (cmd.sel == SEL_DIGIT) && (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= CNT_W'(1);
				pos_q <= DIGIT_DEPTH'(2);
			end else if (cmd.shift && grow) begin
				cnt_q <= cnt_q + CNT_W'(1);
				pos_q <= pos_q << 1;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.pad_zero = (pad_left_q == '0);
	assign sts.neg = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_pos_tracks_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(1) && cnt_q < CNT_W'(DIGIT_DEPTH))
		|-> pos_q == (DIGIT_DEPTH'(1) << cnt_q))
		else $error("digit position mark out of step with digit count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DIGIT_DEPTH))
		else $error("digit count beyond digit store");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_DIGIT) |-> idx_q < IDX_W'(DIGIT_DEPTH))
		else $error("digit read outside digit store");

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, ties the sequencer to the datapath
// depends on i2a_pkg, i2a_ctrl and i2a_dp
//
// Formats one number per input transaction as ASCII text, one output transaction
// per character, most significant first, last set on the final digit. Decimal or
// upper-case hex; in signed mode a negative value is negated and preceded by '-'.
// Pad characters ('0' or space) come before everything, the sign included, up to
// pad_width, which saturates at MAX_PAD. Only the low VALUE_BITS bits of value
// are used. One item passes through acceptance, conversion (the digit register
// takes one bit of the magnitude per cycle through a shift and, in decimal mode,
// add-3 stage), a setup step, the pad phase, the sign if any and the digits;
// each character is issued only while the output register is free (out_valid
// low or out_ready high). A new number is taken once the last character is in
// the output register.
module integer_to_ascii_formatter #(
	parameter int MAX_PAD    = 63,
	parameter int VALUE_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  i2a_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output i2a_pkg::out_t out_data
);
	import i2a_pkg::*;

	cmd_t cmd;
	sts_t sts;

	i2a_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2a_dp #(
		.MAX_PAD   (MAX_PAD),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> verif/tb_integer_to_ascii_formatter.sv
// tb_integer_to_ascii_formatter: self-checking testbench of the integer to ascii formatter
// drives directed and random numbers through valid/ready under varied idling and checks
// every emitted character against a local formatter; depends on i2a_pkg and the rtl
module tb_integer_to_ascii_formatter;
	import i2a_pkg::*;

	localparam int MAX_PAD = 63;
	localparam int VALUE_BITS = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 150;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int PHASE_COUNT = 5;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int send_gap_pct = 0;
	int ready_stall_pct = 0;
	int quiet_cycles = 0;

	class char_scoreboard;
		out_t expected_chars[$];
		int error_count = 0;

		// formats one accepted number into the characters the block must emit
		function void note_number(in_t item);
			logic [VALUE_BITS-1:0] magnitude;
			logic [3:0] digits[20];
			logic negative;
			int count;
			int pad;
			int fill;
			out_t ch;
			magnitude = item.value[VALUE_BITS-1:0];
			negative = item.signed_mode && item.value[VALUE_BITS-1];
			if (negative)
				magnitude = -magnitude;
			count = 0;
			do begin
				if (item.base_ten) begin
					digits[count] = 4'(magnitude % DEC_RADIX);
					magnitude = magnitude / DEC_RADIX;
				end else begin
					digits[count] = magnitude[3:0];
					magnitude = magnitude >> 4;
				end
				count++;
			end while (magnitude != 0);
			pad = (item.pad_width > MAX_PAD) ? MAX_PAD : int'(item.pad_width);
			fill = pad - count - int'(negative);
			ch.last = 1'b0;
			ch.character = item.zero_fill ? CH_ZERO : CH_SPACE;
			for (int i = 0; i < fill; i++)
				expected_chars.push_back(ch);
			if (negative) begin
				ch.character = CH_MINUS;
				expected_chars.push_back(ch);
			end
			for (int i = count - 1; i >= 0; i--) begin
				if (digits[i] < DEC_RADIX)
					ch.character = CH_ZERO + 8'(digits[i]);
				else
					ch.character = CH_UPPER_A + 8'(digits[i]) - 8'(DEC_RADIX);
				ch.last = (i == 0);
				expected_chars.push_back(ch);
			end
		endfunction

		function void check_char(out_t got);
			out_t want;
			if (expected_chars.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected character %h last %b", got.character, got.last);
				return;
			end
			want = expected_chars.pop_front();
			if (got.character !== want.character || got.last !== want.last) begin
				error_count++;
				if (error_count <= 10)
					$display("mismatch: expected char %h last %b, got char %h last %b",
						want.character, want.last, got.character, got.last);
			end
		endfunction
	endclass

	char_scoreboard scoreboard = new();

	integer_to_ascii_formatter #(
		.MAX_PAD(MAX_PAD),
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			scoreboard.check_char(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic in_t number_item(logic [63:0] value, logic ten, logic zf, logic sm,
			logic [7:0] pad);
		in_t item;
		item.value = value;
		item.base_ten = ten;
		item.zero_fill = zf;
		item.signed_mode = sm;
		item.pad_width = pad;
		return item;
	endfunction

	function automatic in_t random_number();
		in_t item;
		int span;
		item.value = {$urandom(), $urandom()};
		span = $urandom_range(1, 64);
		if (span < 64)
			item.value &= (64'd1 << span) - 64'd1;
		case ($urandom_range(0, 11))
			0: item.value = '0;
			1: item.value = {1'b1, 63'd0};
			2: item.value = '1;
			3, 4: item.value = -item.value;
			default: ;
		endcase
		item.base_ten = 1'($urandom_range(0, 1));
		item.zero_fill = 1'($urandom_range(0, 1));
		item.signed_mode = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: item.pad_width = 8'($urandom_range(0, 255));
			1, 2: item.pad_width = 8'($urandom_range(0, 63));
			default: item.pad_width = 8'($urandom_range(0, 24));
		endcase
		return item;
	endfunction

	task automatic send_number(in_t item);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_gap_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		scoreboard.note_number(item);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (scoreboard.expected_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_t directed[$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;

		directed.push_back(number_item(64'd0, 1'b0, 1'b0, 1'b0, 8'd0));
		directed.push_back(number_item(64'd0, 1'b1, 1'b1, 1'b1, 8'd5));
		directed.push_back(number_item('1, 1'b1, 1'b0, 1'b0, 8'd0));
		directed.push_back(number_item('1, 1'b0, 1'b1, 1'b0, 8'd20));
		directed.push_back(number_item('1, 1'b1, 1'b1, 1'b1, 8'd4));
		directed.push_back(number_item({1'b1, 63'd0}, 1'b1, 1'b0, 1'b1, 8'd0));
		directed.push_back(number_item({1'b1, 63'd0}, 1'b0, 1'b1, 1'b1, 8'd25));
		directed.push_back(number_item(-64'd5, 1'b1, 1'b1, 1'b1, 8'd5));
		directed.push_back(number_item(-64'd5, 1'b1, 1'b0, 1'b1, 8'd5));
		directed.push_back(number_item(-64'd5, 1'b1, 1'b0, 1'b0, 8'd0));
		directed.push_back(number_item(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 1'b0, 8'd0));
		directed.push_back(number_item(64'd10000000000000000000, 1'b1, 1'b0, 1'b0, 8'd1));
		directed.push_back(number_item(64'd12345, 1'b1, 1'b0, 1'b0, 8'd255));
		directed.push_back(number_item(64'd7, 1'b1, 1'b1, 1'b0, 8'd63));
		directed.push_back(number_item(64'd7, 1'b0, 1'b1, 1'b0, 8'd64));
		directed.push_back(number_item(64'd12345, 1'b1, 1'b1, 1'b0, 8'd5));
		directed.push_back(number_item(64'd12345, 1'b1, 1'b1, 1'b0, 8'd3));
		directed.push_back(number_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 8'd22));
		directed.push_back(number_item(64'd0, 1'b0, 1'b0, 1'b0, 8'd128));
		directed.push_back(number_item(64'hABCDEF, 1'b0, 1'b0, 1'b1, 8'd6));
		directed.push_back(number_item(-64'd255, 1'b0, 1'b1, 1'b1, 8'd10));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_number(directed[i]);
		wait_drained();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				1: begin
					send_gap_pct = 58;
					ready_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					ready_stall_pct = 58;
				end
				3: begin
					send_gap_pct = 20;
					ready_stall_pct = 20;
				end
				default: begin
					send_gap_pct = 0;
					ready_stall_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_number(random_number());
			// hold off the sender until the block has emitted everything
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (scoreboard.error_count == 0 && scoreboard.expected_chars.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
